FILE: src/tsst_pkg.sv
// Package for the TCP send sequence tracker: codes, reset values and the
// transaction and configuration structs shared by every file of the block.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tsst_pkg;

  localparam int DEF_SEND_BUF_BYTES = 4096;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [15:0] MSS_RESET    = 16'd536;
  localparam logic [15:0] WINDOW_VALUE = 16'd1024;
  localparam logic [31:0] ISN_RESET    = 32'd0;

  typedef enum logic [2:0] {
    ACT_WRITE    = 3'd0,
    ACT_SEND_SYN = 3'd1,
    ACT_SEND_FIN = 3'd2,
    ACT_TRANSMIT = 3'd3,
    ACT_ACK_IN   = 3'd4,
    ACT_SEND_ACK = 3'd5
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MSS         = 2'd0,
    CFG_LOCAL_PORT  = 2'd1,
    CFG_REMOTE_PORT = 2'd2,
    CFG_ISN         = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] write_len;
    logic [31:0] ack_number;
    logic [31:0] recv_next;
    logic        peer_syn_seen;
  } cmd_item_t;

  typedef struct packed {
    logic        segment_valid;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic        flag_syn;
    logic        flag_ack;
    logic        flag_fin;
    logic [15:0] window;
    logic [12:0] data_offset;
    logic [12:0] data_len;
    logic [12:0] accepted_len;
  } seg_item_t;

  typedef struct packed {
    logic [15:0] mss;
    logic [15:0] src_port_num;
    logic [15:0] dst_port_num;
    logic        isn_load;
    logic [31:0] isn_value;
  } cfg_t;

endpackage

`default_nettype wire

FILE: src/tsst_if.sv
// Valid/ready channel interfaces for the command and segment transactions.
// Depends on tsst_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tsst_cmd_if
  import tsst_pkg::*;
  ();
  logic      valid;
  logic      ready;
  cmd_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsst_seg_if
  import tsst_pkg::*;
  ();
  logic      valid;
  logic      ready;
  seg_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/tcp_send_sequence_tracker_top.sv
// Top level of the TCP send sequence tracker: command input register,
// result register and handshakes. Depends on tsst_pkg, tsst_if,
// tsst_cfg_regs and tsst_engine.
`timescale 1ns / 1ps
`default_nettype none

// This block keeps the send-side sequence state of one TCP connection and
// answers every command transaction on cmd with exactly one result
// transaction on result. A command is first captured in an input register;
// once the result register is free or drains, the engine evaluates it
// against the connection state, updates that state and loads the result
// register. The result is therefore offered from the result register once
// its command has left the input register. Throughput is one command per
// cycle while results are taken; the only loop is the state register update. The
// input register takes a new command whenever it is empty or its contents
// move on in the same cycle, so while a result waits on result one more
// command can still be captured; after that cmd.ready stays low until the
// result is taken. Configuration writes
// are taken at any cycle with cfg_we high; they are meant for idle periods.
// Writing the initial sequence register reloads both the oldest
// unacknowledged and the next-to-send sequence numbers. A result whose
// segment_valid is low carries zeros except for accepted_len.

module tcp_send_sequence_tracker_top
  import tsst_pkg::*;
#(
  parameter int SEND_BUF_BYTES = DEF_SEND_BUF_BYTES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  tsst_cmd_if.sink                   cmd,
  tsst_seg_if.source                 result
);

  cfg_t      cfg;
  logic      in_valid;
  cmd_item_t in_data;
  logic      out_valid;
  seg_item_t out_data;
  seg_item_t seg;
  logic      advance;

  // The held command moves on when the result register is free or drains.
  assign advance   = in_valid && (!out_valid || result.ready);
  assign cmd.ready = !in_valid || advance;

  tsst_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tsst_engine #(
    .SEND_BUF_BYTES (SEND_BUF_BYTES)
  ) u_engine (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .item    (in_data),
    .seg     (seg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      in_data <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= seg;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

`ifndef SYNTHESIS
  // A held command that cannot move on must still be there next cycle.
  a_hold_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_data))
    else $error("held command lost or changed");

  a_empty_header: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.segment_valid |->
      out_data.seg_seq == 32'd0 && out_data.seg_ack == 32'd0 &&
      !out_data.flag_syn && !out_data.flag_ack && !out_data.flag_fin &&
      out_data.data_len == 13'd0 && out_data.window == 16'd0)
    else $error("result without segment carries header fields");

  a_write_no_segment: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.accepted_len != 13'd0 |-> !out_data.segment_valid)
    else $error("write result also carries a segment");

  a_window: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.segment_valid |-> out_data.window == WINDOW_VALUE)
    else $error("segment with wrong window");
`endif

endmodule

`default_nettype wire

FILE: src/tsst_cfg_regs.sv
// Configuration register file: MSS and port numbers, plus the load strobe
// for the initial sequence number. Depends on tsst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsst_cfg_regs
  import tsst_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  logic [15:0] mss;
  logic [15:0] src_port_num;
  logic [15:0] dst_port_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      mss          <= MSS_RESET;
      src_port_num <= 16'd0;
      dst_port_num <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_MSS:         mss <= cfg_data[15:0];
        CFG_LOCAL_PORT:  src_port_num <= cfg_data[15:0];
        CFG_REMOTE_PORT: dst_port_num <= cfg_data[15:0];
        CFG_ISN: begin
          // The sequence value goes straight into the tracker state.
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.mss          = mss;
    cfg.src_port_num = src_port_num;
    cfg.dst_port_num = dst_port_num;
    cfg.isn_load     = cfg_we && (cfg_reg_e'(cfg_index) == CFG_ISN);
    cfg.isn_value    = cfg_data[31:0];
  end

endmodule

`default_nettype wire

FILE: src/tsst_engine.sv
// Sequence state of the connection and the combinational logic that turns
// one command into its result and next state. Depends on tsst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsst_engine
  import tsst_pkg::*;
#(
  parameter int SEND_BUF_BYTES = DEF_SEND_BUF_BYTES
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire logic      advance,
  input  wire cmd_item_t item,
  output seg_item_t      seg
);

  localparam int BW = $clog2(SEND_BUF_BYTES + 1);
  localparam int CW = BW + 16;
  localparam logic [BW-1:0] BUF_MAX = BW'(SEND_BUF_BYTES);

  logic [31:0]   oldest_unacked, oldest_unacked_next;
  logic [31:0]   next_to_send, next_to_send_next;
  logic [BW-1:0] buffered_count, buffered_count_next;
  logic          syn_pending, syn_pending_next;
  logic          fin_pending, fin_pending_next;

  // Transmit path.
  logic               syn_eff, fin_eff;
  logic [31:0]        doff;
  logic signed [33:0] dlen_raw, mss_ext, dlen;
  logic               tx_ok;
  logic [31:0]        nts_tx;

  // Acknowledge path.
  logic [31:0]   ou_base, ack_cnt, unacked, cur;
  logic          cur_pos, cur_gt_bc;
  logic [BW-1:0] removed;

  // Write path.
  logic [BW-1:0] space_left;
  logic [CW-1:0] wlen_ext, free_ext, wr;

  always_comb begin
    syn_eff  = syn_pending || (item.action == ACT_SEND_SYN);
    fin_eff  = fin_pending || (item.action == ACT_SEND_FIN);
    doff     = next_to_send - oldest_unacked;
    dlen_raw = $signed({{(34-BW){1'b0}}, buffered_count}) - $signed({{2{doff[31]}}, doff});
    mss_ext  = $signed({18'd0, cfg.mss});
    dlen     = (dlen_raw > mss_ext) ? mss_ext : dlen_raw;
    tx_ok    = !dlen[33];
    nts_tx   = next_to_send + dlen[31:0] + {31'd0, syn_eff} + {31'd0, fin_eff};

    ou_base   = oldest_unacked + {31'd0, syn_pending};
    ack_cnt   = item.ack_number - ou_base;
    unacked   = next_to_send - ou_base;
    cur       = ($signed(ack_cnt) > $signed(unacked)) ? unacked : ack_cnt;
    cur_pos   = !cur[31] && (cur != 32'd0);
    cur_gt_bc = cur > {{(32-BW){1'b0}}, buffered_count};
    removed   = cur_gt_bc ? buffered_count : cur[BW-1:0];

    space_left = BUF_MAX - buffered_count;
    wlen_ext   = {{BW{1'b0}}, item.write_len};
    free_ext   = {16'd0, space_left};
    wr         = (wlen_ext > free_ext) ? free_ext : wlen_ext;
  end

  always_comb begin
    oldest_unacked_next = oldest_unacked;
    next_to_send_next   = next_to_send;
    buffered_count_next = buffered_count;
    syn_pending_next    = syn_pending;
    fin_pending_next    = fin_pending;
    seg                 = '0;

    unique case (item.action)
      ACT_WRITE: begin
        buffered_count_next = buffered_count + wr[BW-1:0];
        seg.accepted_len    = wr[12:0];
      end
      ACT_SEND_SYN, ACT_SEND_FIN, ACT_TRANSMIT: begin
        syn_pending_next = syn_eff;
        fin_pending_next = fin_eff;
        if (tx_ok) begin
          next_to_send_next = nts_tx;
          seg.segment_valid = 1'b1;
          seg.src_port      = cfg.src_port_num;
          seg.dst_port      = cfg.dst_port_num;
          seg.seg_seq       = next_to_send;
          seg.seg_ack       = item.recv_next;
          seg.flag_syn      = syn_eff;
          seg.flag_ack      = item.peer_syn_seen;
          seg.flag_fin      = fin_eff;
          seg.window        = WINDOW_VALUE;
          seg.data_offset   = doff[12:0];
          seg.data_len      = dlen[12:0];
        end
      end
      ACT_ACK_IN: begin
        oldest_unacked_next = ou_base;
        syn_pending_next    = 1'b0;
        if (cur_pos) begin
          oldest_unacked_next = ou_base + cur;
          buffered_count_next = buffered_count - removed;
          // Anything acknowledged beyond the buffered data covers the FIN.
          if (cur_gt_bc) begin
            fin_pending_next = 1'b0;
          end
        end
      end
      ACT_SEND_ACK: begin
        seg.segment_valid = 1'b1;
        seg.src_port      = cfg.src_port_num;
        seg.dst_port      = cfg.dst_port_num;
        seg.seg_seq       = next_to_send;
        seg.seg_ack       = item.recv_next;
        seg.flag_syn      = syn_pending;
        seg.flag_ack      = 1'b1;
        seg.window        = WINDOW_VALUE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_unacked <= ISN_RESET;
      next_to_send   <= ISN_RESET;
      buffered_count <= '0;
      syn_pending    <= 1'b0;
      fin_pending    <= 1'b0;
    end else if (cfg.isn_load) begin
      oldest_unacked <= cfg.isn_value;
      next_to_send   <= cfg.isn_value;
    end else if (advance) begin
      oldest_unacked <= oldest_unacked_next;
      next_to_send   <= next_to_send_next;
      buffered_count <= buffered_count_next;
      syn_pending    <= syn_pending_next;
      fin_pending    <= fin_pending_next;
    end
  end

endmodule

`default_nettype wire

FILE: test/tcp_send_sequence_tracker_checker.sv
`timescale 1ns / 1ps
// Checker for the TCP send sequence tracker: follows configuration writes and
// command transactions, predicts each segment header and compares it with the
// block's result transactions. Depends on tsst_pkg and tsst_if.

module tcp_send_sequence_tracker_checker
  import tsst_pkg::*;
#(
  parameter int SEND_BUF_BYTES = DEF_SEND_BUF_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tsst_cmd_if                   cmd,
  tsst_seg_if                   result,
  output int                    failures,
  output int                    outstanding,
  output logic [31:0]           snd_una,
  output logic [31:0]           snd_nxt
);

  logic [15:0] mss;
  logic [15:0] src_port_num;
  logic [15:0] dst_port_num;
  logic [31:0] una;
  logic [31:0] nxt;
  int          buffered;
  logic        syn_pend;
  logic        fin_pend;
  seg_item_t   expected_segs[$];

  function automatic seg_item_t header(logic [31:0] rnext, logic ack_flag);
    seg_item_t s;
    s = '0;
    s.segment_valid = 1'b1;
    s.src_port      = src_port_num;
    s.dst_port      = dst_port_num;
    s.seg_seq       = nxt;
    s.seg_ack       = rnext;
    s.flag_syn      = syn_pend;
    s.flag_ack      = ack_flag;
    s.window        = WINDOW_VALUE;
    return s;
  endfunction

  // A segment goes out only when the bytes past the send offset, clamped to
  // the MSS, are not negative; only then does the next sequence move.
  function automatic seg_item_t transmit_segment(cmd_item_t c);
    seg_item_t s;
    int        offset;
    longint    seg_len;
    s = '0;
    offset  = int'(nxt - una);
    seg_len = longint'(buffered) - longint'(offset);
    if (seg_len > longint'(mss)) seg_len = longint'(mss);
    if (seg_len >= 0) begin
      s = header(c.recv_next, c.peer_syn_seen);
      s.flag_fin    = fin_pend;
      s.data_offset = offset[12:0];
      s.data_len    = seg_len[12:0];
      nxt = nxt + seg_len[31:0] + 32'(syn_pend) + 32'(fin_pend);
    end
    return s;
  endfunction

  function automatic void take_ack(logic [31:0] ackno);
    int acked;
    int unacked;
    int freed;
    if (syn_pend) begin
      una      = una + 32'd1;
      syn_pend = 1'b0;
    end
    acked   = int'(ackno - una);
    unacked = int'(nxt - una);
    if (unacked < acked) acked = unacked;
    if (acked > 0) begin
      una      = una + 32'(acked);
      freed    = (acked > buffered) ? buffered : acked;
      buffered = buffered - freed;
      acked    = acked - freed;
      // Whatever is acknowledged beyond the buffered bytes covers the FIN.
      if (fin_pend && acked != 0) fin_pend = 1'b0;
    end
  endfunction

  function automatic seg_item_t predict_segment(cmd_item_t c);
    seg_item_t s;
    int        free_bytes;
    int        taken;
    s = '0;
    case (c.action)
      ACT_WRITE: begin
        free_bytes = SEND_BUF_BYTES - buffered;
        if (free_bytes > 0) begin
          taken = (int'(c.write_len) > free_bytes) ? free_bytes : int'(c.write_len);
          buffered = buffered + taken;
          s.accepted_len = taken[12:0];
        end
      end
      ACT_SEND_SYN: begin
        syn_pend = 1'b1;
        s = transmit_segment(c);
      end
      ACT_SEND_FIN: begin
        fin_pend = 1'b1;
        s = transmit_segment(c);
      end
      ACT_TRANSMIT: s = transmit_segment(c);
      ACT_ACK_IN:   take_ack(c.ack_number);
      ACT_SEND_ACK: s = header(c.recv_next, 1'b1);
      default: ;
    endcase
    return s;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      failures++;
    end
  endtask

  task automatic compare_segment(input seg_item_t want, input seg_item_t got);
    check_field("segment_valid", 32'(want.segment_valid), 32'(got.segment_valid));
    check_field("src_port", 32'(want.src_port), 32'(got.src_port));
    check_field("dst_port", 32'(want.dst_port), 32'(got.dst_port));
    check_field("seg_seq", want.seg_seq, got.seg_seq);
    check_field("seg_ack", want.seg_ack, got.seg_ack);
    check_field("flag_syn", 32'(want.flag_syn), 32'(got.flag_syn));
    check_field("flag_ack", 32'(want.flag_ack), 32'(got.flag_ack));
    check_field("flag_fin", 32'(want.flag_fin), 32'(got.flag_fin));
    check_field("window", 32'(want.window), 32'(got.window));
    check_field("data_offset", 32'(want.data_offset), 32'(got.data_offset));
    check_field("data_len", 32'(want.data_len), 32'(got.data_len));
    check_field("accepted_len", 32'(want.accepted_len), 32'(got.accepted_len));
  endtask

  always @(posedge clk) begin
    seg_item_t got;
    if (rst) begin
      mss          = MSS_RESET;
      src_port_num = '0;
      dst_port_num = '0;
      una          = ISN_RESET;
      nxt          = ISN_RESET;
      buffered     = 0;
      syn_pend     = 1'b0;
      fin_pend     = 1'b0;
      expected_segs.delete();
    end else begin
      if (result.valid && result.ready) begin
        got = result.data;
        if (expected_segs.size() == 0) begin
          $display("%0t: segment expected none, got %h", $time, got);
          failures++;
        end else begin
          compare_segment(expected_segs.pop_front(), got);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_MSS:         mss = cfg_data[15:0];
          CFG_LOCAL_PORT:  src_port_num = cfg_data[15:0];
          CFG_REMOTE_PORT: dst_port_num = cfg_data[15:0];
          CFG_ISN: begin
            una = cfg_data;
            nxt = cfg_data;
          end
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) expected_segs.push_back(predict_segment(cmd.data));
    end
    snd_una     <= una;
    snd_nxt     <= nxt;
    outstanding <= expected_segs.size();
  end

endmodule

FILE: test/tcp_send_sequence_tracker_top_test.sv
`timescale 1ns / 1ps
// Top of the TCP send sequence tracker test: clock, reset, configuration
// phases and command stimulus, with the checker beside the block.
// Depends on tsst_pkg, tsst_if, the block's RTL and the checker.

module tcp_send_sequence_tracker_top_test;
  import tsst_pkg::*;

  // Action codes 6 and 7 are not defined; the block must answer them with
  // an all-zero result.
  localparam logic [2:0] ACT_UNUSED_LO = 3'd6;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 145;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    failures;
  int                    outstanding;
  logic [31:0]           snd_una;
  logic [31:0]           snd_nxt;
  int                    cycles;

  tsst_cmd_if cmd_ch ();
  tsst_seg_if seg_ch ();

  tcp_send_sequence_tracker_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .result    (seg_ch)
  );

  tcp_send_sequence_tracker_checker tracker_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd_ch),
    .result      (seg_ch),
    .failures    (failures),
    .outstanding (outstanding),
    .snd_una     (snd_una),
    .snd_nxt     (snd_nxt)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog: a run that never drains its expected segments ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic cmd_item_t make_cmd(logic [2:0] act, logic [15:0] wlen,
                                         logic [31:0] ackno, logic [31:0] rnext,
                                         logic peer);
    cmd_item_t c;
    c.action        = act;
    c.write_len     = wlen;
    c.ack_number    = ackno;
    c.recv_next     = rnext;
    c.peer_syn_seen = peer;
    return c;
  endfunction

  // Random commands lean toward a working connection: writes and transmits
  // keep data in flight, and most acknowledgements land inside the window
  // that the checker currently tracks, so buffer space is actually freed and
  // FINs actually get acknowledged. The rest are stale or wild acks, repeated
  // SYN and FIN marks, pure ACKs and the undefined codes.
  function automatic cmd_item_t random_command();
    cmd_item_t   c;
    logic [31:0] span;
    int          pick;
    c.action        = ACT_TRANSMIT;
    c.write_len     = 16'($urandom);
    c.ack_number    = $urandom;
    c.recv_next     = $urandom;
    c.peer_syn_seen = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      c.action = ACT_WRITE;
      if ($urandom_range(0, 9) != 0) c.write_len = 16'($urandom_range(0, 700));
    end else if (pick < 50) begin
      c.action = ACT_TRANSMIT;
    end else if (pick < 78) begin
      c.action = ACT_ACK_IN;
      span = snd_nxt - snd_una;
      case ($urandom_range(0, 9))
        0: ;
        1: c.ack_number = snd_una - 32'($urandom_range(1, 64));
        default: begin
          if (span <= 32'd8192) c.ack_number = snd_una + 32'($urandom_range(0, span + 1));
        end
      endcase
    end else if (pick < 84) begin
      c.action = ACT_SEND_SYN;
    end else if (pick < 89) begin
      c.action = ACT_SEND_FIN;
    end else if (pick < 97) begin
      c.action = ACT_SEND_ACK;
    end else begin
      c.action = $urandom_range(0, 1) ? ACT_UNUSED_LO : ACT_UNUSED_HI;
    end
    return c;
  endfunction

  // All sender tasks start and end at a falling edge. valid stays high from
  // one transaction to the next when no gap is inserted.
  task automatic drive_cmd(input cmd_item_t c);
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int n);
    repeat (n) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Hold the sender until every expected segment has come back, then wait a
  // further DRAIN_CYCLES for the two-stage pipeline to empty.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Four back-to-back register writes. The upper half of the data bus gets
  // noise for the 16-bit registers, which must ignore it.
  task automatic apply_settings(input logic [15:0] mss, input logic [15:0] lport,
                                input logic [15:0] rport, input logic [31:0] isn);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MSS;
    cfg_data  <= {16'($urandom), mss};
    @(negedge clk);
    cfg_index <= CFG_LOCAL_PORT;
    cfg_data  <= {16'($urandom), lport};
    @(negedge clk);
    cfg_index <= CFG_REMOTE_PORT;
    cfg_data  <= {16'($urandom), rport};
    @(negedge clk);
    cfg_index <= CFG_ISN;
    cfg_data  <= isn;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // The result side stalls on its own schedule: stretches of constant
  // readiness, coin-flip readiness, mostly stalled, and a periodic pattern.
  initial begin
    int beat;
    beat = 0;
    seg_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      beat++;
      case ((beat / 97) % 4)
        0: seg_ch.ready <= 1'b1;
        1: seg_ch.ready <= ($urandom_range(0, 1) == 1);
        2: seg_ch.ready <= ($urandom_range(0, 3) == 0);
        default: seg_ch.ready <= ((beat % 5) != 0);
      endcase
    end
  end

  initial begin
    int burst_left;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = CFG_MSS;
    cfg_data     = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part with reset settings (MSS 536, ports 0, sequence 0).
    drive_cmd(make_cmd(ACT_SEND_ACK, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
    drive_cmd(make_cmd(ACT_UNUSED_LO, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    drive_cmd(make_cmd(ACT_UNUSED_HI, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    drive_cmd(make_cmd(ACT_WRITE, 16'h0000, 32'h0, 32'h1234_5678, 1'b0));
    // SYN with an empty buffer, then a repeated SYN before any ack, which
    // comes out with a negative length and sends nothing.
    drive_cmd(make_cmd(ACT_SEND_SYN, 16'h0, 32'h0, 32'h0000_0000, 1'b0));
    drive_cmd(make_cmd(ACT_SEND_SYN, 16'h0, 32'h0, 32'h8000_0000, 1'b1));
    drive_cmd(make_cmd(ACT_ACK_IN, 16'h0, snd_nxt, 32'h0, 1'b0));
    // Fill the buffer completely; the next write finds it full.
    drive_cmd(make_cmd(ACT_WRITE, 16'hFFFF, 32'h0, 32'h0, 1'b1));
    drive_cmd(make_cmd(ACT_WRITE, 16'h0001, 32'h0, 32'h0, 1'b0));
    drive_cmd(make_cmd(ACT_TRANSMIT, 16'h0, 32'h0, 32'h7FFF_FFFF, 1'b1));
    drive_cmd(make_cmd(ACT_TRANSMIT, 16'h0, 32'h0, 32'h0000_0001, 1'b0));
    drive_cmd(make_cmd(ACT_ACK_IN, 16'h0, 32'hFFFF_FFFF, 32'h0, 1'b0));
    drive_cmd(make_cmd(ACT_ACK_IN, 16'h0, snd_una + 32'd1000, 32'h0, 1'b1));
    drive_cmd(make_cmd(ACT_SEND_FIN, 16'h0, 32'h0, 32'hFFFF_FFFF, 1'b1));
    drive_cmd(make_cmd(ACT_SEND_FIN, 16'h0, 32'h0, 32'h0000_FFFF, 1'b0));
    drive_cmd(make_cmd(ACT_ACK_IN, 16'h0, 32'h7FFF_FFFF, 32'h0, 1'b0));
    drive_cmd(make_cmd(ACT_SEND_SYN, 16'h0, 32'h0, 32'hFFFF_0000, 1'b1));

    // Reloading the sequence registers while a SYN is still pending lets
    // the SYN's ack push the unacknowledged number past the next one, so the
    // following transmits report a negative offset; MSS zero clamps length.
    drain_results();
    apply_settings(16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF);
    drive_cmd(make_cmd(ACT_ACK_IN, 16'h0, 32'h0000_0000, 32'h0, 1'b0));
    drive_cmd(make_cmd(ACT_TRANSMIT, 16'h0, 32'h0, 32'hAAAA_5555, 1'b1));
    drive_cmd(make_cmd(ACT_TRANSMIT, 16'h0, 32'h0, 32'h5555_AAAA, 1'b0));
    drive_cmd(make_cmd(ACT_SEND_ACK, 16'h0, 32'h0, 32'h0000_0000, 1'b0));
    drive_cmd(make_cmd(ACT_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 1'b1));

    // Random phases, each under its own settings and each opened like a
    // connection: SYN, then the ack of everything sent so far.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      case (phase)
        0: apply_settings(16'd1, 16'hFFFF, 16'h0000, 32'hFFFF_FFF0);
        1: apply_settings(16'hFFFF, 16'h0000, 16'hFFFF, 32'h7FFF_FFF0);
        2: apply_settings(16'($urandom_range(1, 1460)), 16'($urandom), 16'($urandom),
                          $urandom);
        3: apply_settings(16'd0, 16'($urandom), 16'($urandom), 32'h0000_0000);
        4: apply_settings(16'd536, 16'($urandom), 16'($urandom), 32'hFFFF_FFFF);
        default: apply_settings(16'($urandom_range(1, 64)), 16'($urandom),
                                16'($urandom), $urandom);
      endcase
      drive_cmd(make_cmd(ACT_SEND_SYN, 16'($urandom), $urandom, $urandom, 1'b0));
      drive_cmd(make_cmd(ACT_ACK_IN, 16'($urandom), snd_nxt, $urandom, 1'b1));
      burst_left = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (burst_left == 0) begin
          idle_gap($urandom_range(1, 8));
          burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        drive_cmd(random_command());
      end
    end

    drain_results();
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
